### rtl/round_robin_slice_scheduler_macros.svh
// Assertion macros used by the checker file of the scheduler.
`ifndef ROUND_ROBIN_SLICE_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_SLICE_SCHEDULER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rrs_pkg.sv
package rrs_pkg;

  localparam int MAX_JOBS_DEFAULT = 64;

  localparam int TIME_W   = 16;
  localparam int CLOCK_W  = 22;
  localparam int DIFF_W   = 23;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_RUN      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ALL_DONE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 2'd3;

  localparam logic [PADDR_W-3:0] REG_QUANTUM = 1'b0;
  localparam logic [TIME_W-1:0]  QUANTUM_RESET = 16'd1;

  typedef struct packed {
    logic                capture;
    logic                clear;
    logic                ld_init;
    logic                ld_read;
    logic                ld_shift;
    logic                ld_place;
    logic                st_init;
    logic                st_adv;
    logic                st_read;
    logic                st_exec;
    logic                st_turn;
    logic                st_wait;
    logic                res_write;
    logic [STATUS_W-1:0] res_status;
  } rrs_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            all_done;
    logic            k_zero;
    logic            gt;
    logic            cur_done;
    logic            out_free;
  } rrs_sts_t;

endpackage

### rtl/rrs_ctrl.sv
module rrs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  rrs_pkg::rrs_sts_t sts,
  output rrs_pkg::rrs_cmd_t cmd
);
  import rrs_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_LD_RD    = 4'd2;
  localparam logic [3:0] S_LD_CMP   = 4'd3;
  localparam logic [3:0] S_ST_SCAN  = 4'd4;
  localparam logic [3:0] S_ST_EXEC  = 4'd5;
  localparam logic [3:0] S_ST_TURN  = 4'd6;
  localparam logic [3:0] S_ST_WAIT  = 4'd7;
  localparam logic [3:0] S_OUT      = 4'd8;

  logic [3:0]          state;
  logic [3:0]          state_next;
  logic [STATUS_W-1:0] res;
  logic [STATUS_W-1:0] res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res   <= STATUS_ACCEPTED;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    res_next   = res;
    s_tready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_LOAD: begin
            if (sts.full) begin
              res_next   = STATUS_FULL;
              state_next = S_OUT;
            end else begin
              cmd.ld_init = 1'b1;
              state_next  = S_LD_RD;
            end
          end
          OP_STEP: begin
            if (sts.all_done) begin
              res_next   = STATUS_ALL_DONE;
              state_next = S_OUT;
            end else begin
              cmd.st_init = 1'b1;
              state_next  = S_ST_SCAN;
            end
          end
          OP_CLEAR: begin
            cmd.clear  = 1'b1;
            res_next   = STATUS_ACCEPTED;
            state_next = S_OUT;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_LD_RD: begin
        if (sts.k_zero) begin
          cmd.ld_place = 1'b1;
          res_next     = STATUS_ACCEPTED;
          state_next   = S_OUT;
        end else begin
          cmd.ld_read = 1'b1;
          state_next  = S_LD_CMP;
        end
      end
      S_LD_CMP: begin
        if (sts.gt) begin
          cmd.ld_shift = 1'b1;
          state_next   = S_LD_RD;
        end else begin
          cmd.ld_place = 1'b1;
          res_next     = STATUS_ACCEPTED;
          state_next   = S_OUT;
        end
      end
      S_ST_SCAN: begin
        if (sts.cur_done) begin
          cmd.st_adv = 1'b1;
        end else begin
          cmd.st_read = 1'b1;
          state_next  = S_ST_EXEC;
        end
      end
      S_ST_EXEC: begin
        cmd.st_exec = 1'b1;
        state_next  = S_ST_TURN;
      end
      S_ST_TURN: begin
        cmd.st_turn = 1'b1;
        state_next  = S_ST_WAIT;
      end
      S_ST_WAIT: begin
        cmd.st_wait = 1'b1;
        res_next    = STATUS_RUN;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.res_write = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    cmd.res_status = res;
  end

endmodule

### rtl/rrs_dp.sv
module rrs_dp #(
  parameter  int MAX_JOBS = rrs_pkg::MAX_JOBS_DEFAULT,
  localparam int CNT_W    = $clog2(MAX_JOBS + 1),
  localparam int OUT_W    = CNT_W + rrs_pkg::CLOCK_W + 1 + 2 * rrs_pkg::DIFF_W,
  localparam int TDATA_W  = ((OUT_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rrs_pkg::PADDR_W-1:0]    paddr,
  input  logic [rrs_pkg::PDATA_W-1:0]    pwdata,
  output logic [rrs_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready,
  input  logic [2*rrs_pkg::TIME_W-1:0]   s_tdata,
  input  logic [rrs_pkg::OP_W-1:0]       s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [TDATA_W-1:0]             m_tdata,
  output logic [rrs_pkg::STATUS_W-1:0]   m_tuser,
  input  rrs_pkg::rrs_cmd_t              cmd,
  output rrs_pkg::rrs_sts_t              sts
);
  import rrs_pkg::*;

  localparam int IDX_W = $clog2(MAX_JOBS);

  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] remaining;
  } entry_t;

  entry_t mem [MAX_JOBS];
  entry_t rdata;

  logic [OP_W-1:0]          op;
  logic [TIME_W-1:0]        new_arr;
  logic [TIME_W-1:0]        new_bur;
  logic [CNT_W-1:0]         job_count;
  logic [CNT_W-1:0]         done_count;
  logic [IDX_W-1:0]         cursor;
  logic [IDX_W-1:0]         pos;
  logic [IDX_W-1:0]         sel;
  logic [CLOCK_W-1:0]       clock_now;
  logic [MAX_JOBS-1:0]      done_bits;
  logic [TIME_W-1:0]        quantum;
  logic                     fin;
  logic [CNT_W-1:0]         run_index;
  logic [TIME_W-1:0]        run_arr;
  logic [TIME_W-1:0]        run_bur;
  logic signed [DIFF_W-1:0] turnaround;
  logic signed [DIFF_W-1:0] waiting;

  logic [CNT_W-1:0]   sel_inc;
  logic [IDX_W-1:0]   sel_wrap;
  logic [IDX_W-1:0]   cursor_start;
  logic [IDX_W-1:0]   pos_dec;
  logic               over;
  logic [TIME_W-1:0]  slice_len;
  logic [CLOCK_W:0]   clock_sum;
  logic [CLOCK_W-1:0] clock_sat;
  logic               cfg_write;
  logic               quantum_sel;

  assign sel_inc      = CNT_W'(sel) + CNT_W'(1);
  assign sel_wrap     = (sel_inc < job_count) ? IDX_W'(sel_inc) : '0;
  assign cursor_start = (CNT_W'(cursor) < job_count) ? cursor : '0;
  assign pos_dec      = pos - IDX_W'(1);
  assign over         = rdata.remaining > quantum;
  assign slice_len    = over ? quantum : rdata.remaining;
  assign clock_sum    = {1'b0, clock_now} + (CLOCK_W + 1)'(slice_len);
  // The clock saturates at its all-ones value.
  assign clock_sat    = clock_sum[CLOCK_W] ? '1 : clock_sum[CLOCK_W-1:0];

  assign quantum_sel = (paddr[PADDR_W-1:2] == REG_QUANTUM);
  assign cfg_write   = psel && penable && pwrite && pready;
  assign pready      = 1'b1;
  assign prdata      = quantum_sel ? PDATA_W'(quantum) : '0;

  always_comb begin
    sts          = '0;
    sts.op       = op;
    sts.full     = (job_count == CNT_W'(MAX_JOBS));
    sts.all_done = (done_count >= job_count);
    sts.k_zero   = (pos == '0);
    sts.gt       = (rdata.arrival > new_arr);
    sts.cur_done = done_bits[sel];
    sts.out_free = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_read) begin
      rdata <= mem[pos_dec];
    end else if (cmd.st_read) begin
      rdata <= mem[sel];
    end
    if (cmd.ld_shift) begin
      mem[pos] <= rdata;
    end else if (cmd.ld_place) begin
      mem[pos] <= {new_arr, new_bur, new_bur};
    end else if (cmd.st_exec) begin
      mem[sel] <= {rdata.arrival, rdata.burst, rdata.remaining - slice_len};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_count  <= '0;
      done_count <= '0;
      cursor     <= '0;
      clock_now  <= '0;
      done_bits  <= '0;
      quantum    <= QUANTUM_RESET;
    end else begin
      if (cfg_write && quantum_sel) begin
        quantum <= pwdata[TIME_W-1:0];
      end
      if (cmd.clear) begin
        job_count  <= '0;
        done_count <= '0;
        cursor     <= '0;
        clock_now  <= '0;
        done_bits  <= '0;
      end
      if (cmd.ld_shift) begin
        done_bits[pos] <= done_bits[pos_dec];
      end
      if (cmd.ld_place) begin
        done_bits[pos] <= (new_bur == '0);
        job_count      <= job_count + CNT_W'(1);
        if (new_bur == '0) begin
          done_count <= done_count + CNT_W'(1);
        end
      end
      if (cmd.st_exec) begin
        clock_now <= clock_sat;
        cursor    <= sel_wrap;
        if (!over) begin
          done_bits[sel] <= 1'b1;
          done_count     <= done_count + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op      <= s_tuser;
      new_arr <= s_tdata[TIME_W-1:0];
      new_bur <= s_tdata[2*TIME_W-1:TIME_W];
    end
    if (cmd.ld_init) begin
      pos <= IDX_W'(job_count);
    end else if (cmd.ld_shift) begin
      pos <= pos_dec;
    end
    if (cmd.st_init) begin
      sel <= cursor_start;
    end else if (cmd.st_adv) begin
      sel <= sel_wrap;
    end
    if (cmd.st_exec) begin
      fin       <= !over;
      run_index <= sel_inc;
      run_arr   <= rdata.arrival;
      run_bur   <= rdata.burst;
    end
    if (cmd.st_turn) begin
      turnaround <= fin ? ({1'b0, clock_now} - DIFF_W'(run_arr)) : '0;
    end
    if (cmd.st_wait) begin
      waiting <= fin ? (turnaround - DIFF_W'(run_bur)) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.res_write) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_write) begin
      m_tuser <= cmd.res_status;
      case (cmd.res_status)
        STATUS_RUN: begin
          m_tdata <= TDATA_W'({waiting, turnaround, fin, clock_now, run_index});
        end
        STATUS_ALL_DONE: begin
          m_tdata <= TDATA_W'({clock_now, CNT_W'(0)});
        end
        default: m_tdata <= '0;
      endcase
    end
  end

endmodule

### rtl/round_robin_slice_scheduler.sv
// Load: after dispatch, each entry with a later arrival is read, compared and moved up,
// then the new job is placed and its result goes to the output register.
// Step: dispatch, scan past finished entries at one entry a cycle, execute, turnaround,
// waiting, output. Clear, full table and nothing-to-run answers go straight to output.
// One item is in work at a time; the next word is taken after its result is registered.
// Synchronous reset empties the table, zeroes the clock and sets the quantum to 1.
module round_robin_slice_scheduler #(
  parameter  int MAX_JOBS = rrs_pkg::MAX_JOBS_DEFAULT,
  localparam int CNT_W    = $clog2(MAX_JOBS + 1),
  localparam int OUT_W    = CNT_W + rrs_pkg::CLOCK_W + 1 + 2 * rrs_pkg::DIFF_W,
  localparam int TDATA_W  = ((OUT_W + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rrs_pkg::PADDR_W-1:0]  paddr,
  input  logic [rrs_pkg::PDATA_W-1:0]  pwdata,
  output logic [rrs_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [2*rrs_pkg::TIME_W-1:0] s_tdata,  // arrival, burst
  input  logic [rrs_pkg::OP_W-1:0]     s_tuser,  // operation
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [TDATA_W-1:0]           m_tdata,  // job_index, slice_end, finished,
                                                 // turnaround, waiting, zero fill
  output logic [rrs_pkg::STATUS_W-1:0] m_tuser   // status
);
  import rrs_pkg::*;

  rrs_cmd_t cmd;
  rrs_sts_t sts;

  rrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrs_dp #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

### rtl/rrs_checker.sv
`include "round_robin_slice_scheduler_macros.svh"

module rrs_checker #(
  parameter  int MAX_JOBS = rrs_pkg::MAX_JOBS_DEFAULT,
  localparam int CNT_W    = $clog2(MAX_JOBS + 1),
  localparam int OUT_W    = CNT_W + rrs_pkg::CLOCK_W + 1 + 2 * rrs_pkg::DIFF_W,
  localparam int TDATA_W  = ((OUT_W + 7) / 8) * 8
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [TDATA_W-1:0]           m_tdata,
  input logic [rrs_pkg::STATUS_W-1:0] m_tuser
);
  import rrs_pkg::*;

  logic [CNT_W-1:0]  job_index;
  logic              finished;
  logic [DIFF_W-1:0] turnaround;
  logic [DIFF_W-1:0] waiting;
  logic              is_run;

  assign job_index  = m_tdata[CNT_W-1:0];
  assign finished   = m_tdata[CNT_W+CLOCK_W];
  assign turnaround = m_tdata[CNT_W+CLOCK_W+1 +: DIFF_W];
  assign waiting    = m_tdata[CNT_W+CLOCK_W+1+DIFF_W +: DIFF_W];
  assign is_run     = m_tvalid && (m_tuser == STATUS_RUN);

  `RRS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled word changed")
  `RRS_ASSERT_NOW(a_run_index, is_run, job_index != '0, "slice run without a job")
  `RRS_ASSERT_NOW(a_other_zero, m_tvalid && !is_run, !finished && turnaround == '0 && waiting == '0, "non-slice word has timing fields")
  `RRS_ASSERT_NOW(a_open_zero, is_run && !finished, turnaround == '0 && waiting == '0, "unfinished slice reports times")
  `RRS_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second word taken during work")

endmodule

bind round_robin_slice_scheduler rrs_checker #(.MAX_JOBS(MAX_JOBS)) u_rrs_checker (.*);

### tb/round_robin_slice_scheduler_tb.sv
`timescale 1ns / 100ps

module round_robin_slice_scheduler_tb;
  import rrs_pkg::*;

  localparam int NJOBS         = 64;
  localparam int IDX_W         = 7;
  localparam int OUT_DATA_W    = 80;
  localparam int CLOCK_TOP     = 4194303;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int WORD_TARGET   = 1550;
  localparam int PHASES        = 7;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    job_index;
    logic [CLOCK_W-1:0]  slice_end;
    logic                finished;
    logic [DIFF_W-1:0]   turnaround;
    logic [DIFF_W-1:0]   waiting;
  } slice_report_t;

  logic                    clk      = 1'b0;
  logic                    rst      = 1'b1;
  logic                    psel     = 1'b0;
  logic                    penable  = 1'b0;
  logic                    pwrite   = 1'b0;
  logic [PADDR_W-1:0]      paddr    = '0;
  logic [PDATA_W-1:0]      pwdata   = '0;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [2*TIME_W-1:0]     s_tdata  = '0;
  logic [OP_W-1:0]         s_tuser  = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_tdata;
  logic [STATUS_W-1:0]     m_tuser;

  logic [TIME_W-1:0] quantum_now = QUANTUM_RESET;
  logic [TIME_W-1:0] tab_arrival [NJOBS];
  logic [TIME_W-1:0] tab_burst [NJOBS];
  logic [TIME_W-1:0] tab_left [NJOBS];
  bit                tab_done [NJOBS];
  int                tab_count    = 0;
  int                tab_finished = 0;
  int                run_cursor   = 0;
  int                sim_clock    = 0;

  slice_report_t due_reports[$];
  int            mismatches  = 0;
  int            words_sent  = 0;
  int            cycles      = 0;
  int            hold_cycles = 0;
  bit            quiet       = 1'b0;

  round_robin_slice_scheduler #(.MAX_JOBS(NJOBS)) dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(99) >= 32);
    end
  end

  function automatic void compare_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_result
    slice_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %h %h", $time, m_tuser, m_tdata);
        mismatches++;
      end else begin
        want = due_reports.pop_front();
        compare_field("status", want.status, m_tuser);
        compare_field("job_index", want.job_index, m_tdata[6:0]);
        compare_field("slice_end", want.slice_end, m_tdata[28:7]);
        compare_field("finished", want.finished, m_tdata[29]);
        compare_field("turnaround", want.turnaround, m_tdata[52:30]);
        compare_field("waiting", want.waiting, m_tdata[75:53]);
      end
    end
  end

  task automatic schedule_word(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] arr,
                               input logic [TIME_W-1:0] bur);
    slice_report_t rep;
    int pos, i, k, len, ta, wt;
    bit fin;
    rep = '{STATUS_ACCEPTED, 0, 0, 0, 0, 0};
    case (op)
      OP_LOAD: begin
        if (tab_count >= NJOBS) begin
          rep.status = STATUS_FULL;
        end else begin
          pos = tab_count;
          while (pos > 0 && tab_arrival[pos-1] > arr) pos--;
          for (k = tab_count; k > pos; k--) begin
            tab_arrival[k] = tab_arrival[k-1];
            tab_burst[k]   = tab_burst[k-1];
            tab_left[k]    = tab_left[k-1];
            tab_done[k]    = tab_done[k-1];
          end
          tab_arrival[pos] = arr;
          tab_burst[pos]   = bur;
          tab_left[pos]    = bur;
          tab_done[pos]    = (bur == 0);
          if (bur == 0) tab_finished++;
          tab_count++;
        end
      end
      OP_STEP: begin
        if (tab_finished >= tab_count) begin
          rep.status    = STATUS_ALL_DONE;
          rep.slice_end = CLOCK_W'(sim_clock);
        end else begin
          i = (run_cursor < tab_count) ? run_cursor : 0;
          for (k = 0; k < tab_count && tab_done[i]; k++) i = (i + 1 < tab_count) ? i + 1 : 0;
          if (tab_left[i] > quantum_now) begin
            len = quantum_now;
            fin = 1'b0;
          end else begin
            len = tab_left[i];
            fin = 1'b1;
          end
          tab_left[i] = tab_left[i] - TIME_W'(len);
          sim_clock = (sim_clock + len > CLOCK_TOP) ? CLOCK_TOP : sim_clock + len;
          if (fin) begin
            tab_done[i] = 1'b1;
            tab_finished++;
            ta = sim_clock - int'(tab_arrival[i]);
            wt = ta - int'(tab_burst[i]);
            rep.turnaround = DIFF_W'(ta);
            rep.waiting    = DIFF_W'(wt);
          end
          run_cursor = (i + 1 < tab_count) ? i + 1 : 0;
          rep.status    = STATUS_RUN;
          rep.job_index = IDX_W'(i + 1);
          rep.slice_end = CLOCK_W'(sim_clock);
          rep.finished  = fin;
        end
      end
      OP_CLEAR: begin
        for (k = 0; k < NJOBS; k++) tab_done[k] = 1'b0;
        tab_count    = 0;
        tab_finished = 0;
        run_cursor   = 0;
        sim_clock    = 0;
      end
      default: return;
    endcase
    due_reports.push_back(rep);
  endtask

  task automatic offer_word(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] arr,
                            input logic [TIME_W-1:0] bur);
    if (!quiet && $urandom_range(99) < 32) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while (!quiet && $urandom_range(99) < 32);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {bur, arr};
    do @(posedge clk); while (!s_tready);
    schedule_word(op, arr, bur);
    if (op != OP_UNUSED) words_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_reports.size() != 0) @(posedge clk);
  endtask

  // An ignored word can still keep the block busy after the last result.
  task automatic settle_block();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_quantum(input logic [TIME_W-1:0] value);
    settle_block();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_QUANTUM, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    quantum_now = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    compare_field("quantum", value, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [TIME_W-1:0] any_time();
    return TIME_W'($urandom());
  endfunction

  function automatic logic [TIME_W-1:0] pick_arrival();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return TIME_W'($urandom_range(7));
      default: return any_time();
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_burst();
    int top;
    top = 3 * int'(quantum_now);
    if (top == 0) top = 4;
    if (top > 65535) top = 65535;
    case ($urandom_range(19))
      0, 1:    return '0;
      2:       return '1;
      3, 4:    return quantum_now;
      5, 6, 7: return any_time();
      default: return TIME_W'($urandom_range(top, 1));
    endcase
  endfunction

  function automatic int pick_jobs();
    case ($urandom_range(19))
      0:          return $urandom_range(NJOBS + 2, 40);
      1, 2, 3, 4: return $urandom_range(24, 9);
      default:    return $urandom_range(8, 1);
    endcase
  endfunction

  task automatic run_sequence(input int jobs);
    int cap, n;
    if ($urandom_range(99) < 85) offer_word(OP_CLEAR, any_time(), any_time());
    repeat (jobs) offer_word(OP_LOAD, pick_arrival(), pick_burst());
    cap = 6 * jobs + 8;
    n = 0;
    while (tab_finished < tab_count && n < cap) begin
      offer_word(OP_STEP, any_time(), any_time());
      n++;
      case ($urandom_range(39))
        0: offer_word(OP_UNUSED, any_time(), any_time());
        1: offer_word(OP_LOAD, pick_arrival(), pick_burst());
        2: if ($urandom_range(3) == 0) offer_word(OP_CLEAR, any_time(), any_time());
        default: ;
      endcase
    end
    repeat ($urandom_range(2)) offer_word(OP_STEP, any_time(), any_time());
  endtask

  task automatic test_directed();
    offer_word(OP_STEP, '1, '1);
    offer_word(OP_LOAD, 16'd5, 16'd3);
    offer_word(OP_LOAD, 16'd5, 16'd2);
    offer_word(OP_LOAD, 16'd0, 16'd0);
    offer_word(OP_LOAD, 16'hFFFF, 16'd1);
    offer_word(OP_UNUSED, '1, '1);
    repeat (4) offer_word(OP_STEP, '0, '0);
    offer_word(OP_LOAD, 16'd2, 16'hFFFF);
    repeat (4) offer_word(OP_STEP, '1, '0);
    offer_word(OP_CLEAR, '1, '1);
    write_quantum(16'hFFFF);
    offer_word(OP_LOAD, 16'hFFFF, 16'hFFFF);
    offer_word(OP_LOAD, 16'd0, 16'hFFFF);
    repeat (3) offer_word(OP_STEP, '0, '1);
    write_quantum(16'd0);
    offer_word(OP_CLEAR, '0, '0);
    offer_word(OP_LOAD, 16'd1, 16'd2);
    offer_word(OP_LOAD, 16'd3, 16'd0);
    repeat (2) offer_word(OP_STEP, '0, '0);
    write_quantum(QUANTUM_RESET);
  endtask

  task automatic test_full_table();
    write_quantum(TIME_W'($urandom_range(20, 1)));
    offer_word(OP_CLEAR, any_time(), any_time());
    repeat (NJOBS + 2) offer_word(OP_LOAD, pick_arrival(), pick_burst());
    repeat (20) offer_word(OP_STEP, any_time(), any_time());
    offer_word(OP_LOAD, pick_arrival(), pick_burst());
  endtask

  task automatic test_back_pressure();
    offer_word(OP_CLEAR, any_time(), any_time());
    hold_cycles = HOLD_CYCLES;
    repeat (6) offer_word(OP_LOAD, pick_arrival(), pick_burst());
    repeat (10) offer_word(OP_STEP, any_time(), any_time());
    wait_drained();
    repeat (8) offer_word(OP_STEP, any_time(), any_time());
  endtask

  task automatic test_random();
    logic [TIME_W-1:0] q;
    int goal;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       q = 16'd1;
        1:       q = 16'hFFFF;
        2:       q = 16'd2;
        3:       q = 16'd3;
        4:       q = TIME_W'($urandom_range(1000, 4));
        default: q = TIME_W'($urandom_range(65535, 1));
      endcase
      write_quantum(q);
      quiet = (p == 3);
      goal = words_sent + (WORD_TARGET - words_sent) / (PHASES - p);
      while (words_sent < goal) run_sequence(pick_jobs());
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_table();
    test_back_pressure();
    test_random();
    settle_block();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
